### rtl/tssp_pkg.sv
// Shared types and constants for the timed servo pickup sequencer.
// Used by tssp_ctrl, tssp_pulse and timed_servo_pickup_sequencer; depends on nothing.
package tssp_pkg;

    localparam int unsigned PULSE_W    = 12;
    localparam int unsigned ANGLE_W    = 8;
    localparam int unsigned RANGE_W    = 9;
    localparam int unsigned MS_W       = 16;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned NUM_SERVOS = 5;
    localparam int unsigned CH_W       = $clog2(NUM_SERVOS);

    typedef logic [ANGLE_W-1:0] angle_t;
    typedef logic [PULSE_W-1:0] pulse_t;

    // Servo slots, in output order.
    localparam logic [CH_W-1:0] SERVO_LIFT    = CH_W'(0);
    localparam logic [CH_W-1:0] SERVO_LJAW    = CH_W'(1);
    localparam logic [CH_W-1:0] SERVO_RJAW    = CH_W'(2);
    localparam logic [CH_W-1:0] SERVO_SORTER  = CH_W'(3);
    localparam logic [CH_W-1:0] SERVO_DEPOSIT = CH_W'(4);

    // Item kinds.
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_PICKUP = 2'd1;
    localparam logic [1:0] KIND_MOVE   = 2'd2;

    // Move presets.
    localparam logic [3:0] MOVE_OPEN        = 4'd0;
    localparam logic [3:0] MOVE_CLOSE       = 4'd1;
    localparam logic [3:0] MOVE_LIFT        = 4'd2;
    localparam logic [3:0] MOVE_LOWER       = 4'd3;
    localparam logic [3:0] MOVE_SORT_LEFT   = 4'd4;
    localparam logic [3:0] MOVE_SORT_RIGHT  = 4'd5;
    localparam logic [3:0] MOVE_SORT_CENTER = 4'd6;
    localparam logic [3:0] MOVE_DEP_LEFT    = 4'd7;
    localparam logic [3:0] MOVE_DEP_CENTER  = 4'd8;
    localparam logic [3:0] MOVE_DEP_RIGHT   = 4'd9;
    localparam logic [3:0] MOVE_RESET_POSE  = 4'd10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DLY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = 3'd4;

    // Configuration reset values.
    localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 12'd500;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 12'd2500;
    localparam logic [RANGE_W-1:0] RANGE_RST     = 9'd270;
    localparam logic [MS_W-1:0]    STEP_DLY_RST  = 16'd500;
    localparam logic [MS_W-1:0]    COOLDOWN_RST  = 16'd1000;

    // Preset angles in degrees.
    localparam angle_t ANG_LIFT_UP     = 8'd190;
    localparam angle_t ANG_LIFT_DOWN   = 8'd48;
    localparam angle_t ANG_LJAW_OPEN   = 8'd120;
    localparam angle_t ANG_RJAW_OPEN   = 8'd180;
    localparam angle_t ANG_LJAW_CLOSED = 8'd190;
    localparam angle_t ANG_RJAW_CLOSED = 8'd85;
    localparam angle_t ANG_SORT_LEFT   = 8'd170;
    localparam angle_t ANG_SORT_RIGHT  = 8'd90;
    localparam angle_t ANG_SORT_CENTER = 8'd130;
    localparam angle_t ANG_DEP_LEFT    = 8'd190;
    localparam angle_t ANG_DEP_CENTER  = 8'd130;
    localparam angle_t ANG_DEP_RIGHT   = 8'd85;
    localparam angle_t ANG_DEP_REST    = 8'd0;

    typedef struct packed {
        logic busy;
        logic avail;
        logic taken;
    } status_t;

endpackage

### rtl/tssp_ctrl.sv
// Item decoder and pickup sequence state: timers, servo angles and status.
// Depends on tssp_pkg.
module tssp_ctrl #(
    parameter int TIMER_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          apply,
    input  logic [1:0]                    kind,
    input  logic                          side,
    input  logic [3:0]                    move_code,
    input  logic                          concurrent,
    input  logic [tssp_pkg::MS_W-1:0]     dwell_ms,
    input  logic [tssp_pkg::MS_W-1:0]     cooldown,
    output tssp_pkg::angle_t              angles [tssp_pkg::NUM_SERVOS],
    output tssp_pkg::status_t             status
);

    localparam int CW = (TIMER_BITS > int'(tssp_pkg::MS_W)) ? TIMER_BITS
                                                            : int'(tssp_pkg::MS_W);
    localparam logic [TIMER_BITS-1:0] TIMER_TOP = '1;

    localparam logic [1:0] STEP_CLOSE     = 2'd0;
    localparam logic [1:0] STEP_WAIT_GRIP = 2'd1;
    localparam logic [1:0] STEP_WAIT_LIFT = 2'd2;
    localparam logic [1:0] STEP_FINISH    = 2'd3;

    logic                  active_reg, active_next;
    logic                  side_reg, side_next;
    logic [1:0]            step_reg, step_next;
    logic [TIMER_BITS-1:0] step_el_reg, step_el_next;
    logic [TIMER_BITS-1:0] act_el_reg, act_el_next;
    logic                  held_reg, held_next;
    logic                  taken_reg, taken_next;
    tssp_pkg::angle_t      angle_reg  [tssp_pkg::NUM_SERVOS];
    tssp_pkg::angle_t      angle_next [tssp_pkg::NUM_SERVOS];

    logic [TIMER_BITS-1:0] step_inc, act_inc;
    logic                  delay_hit;
    logic                  known;

    always_comb
    begin
        active_next  = active_reg;
        side_next    = side_reg;
        step_next    = step_reg;
        step_el_next = step_el_reg;
        act_el_next  = act_el_reg;
        held_next    = held_reg;
        taken_next   = 1'b0;
        angle_next   = angle_reg;
        known        = 1'b1;

        step_inc  = (step_el_reg == TIMER_TOP) ? step_el_reg : step_el_reg + 1'b1;
        act_inc   = (act_el_reg == TIMER_TOP) ? act_el_reg : act_el_reg + 1'b1;
        // A delay beyond the timer's saturation value never expires.
        delay_hit = CW'(step_inc) >= CW'(dwell_ms);

        case (kind)
            tssp_pkg::KIND_TICK:
            begin
                step_el_next = step_inc;
                act_el_next  = act_inc;
                if (active_reg)
                begin
                    case (step_reg)
                        STEP_CLOSE:
                        begin
                            angle_next[tssp_pkg::SERVO_LJAW] = tssp_pkg::ANG_LJAW_CLOSED;
                            angle_next[tssp_pkg::SERVO_RJAW] = tssp_pkg::ANG_RJAW_CLOSED;
                            step_next    = STEP_WAIT_GRIP;
                            step_el_next = '0;
                        end
                        STEP_WAIT_GRIP:
                        begin
                            if (delay_hit)
                            begin
                                angle_next[tssp_pkg::SERVO_SORTER] =
                                    side_reg ? tssp_pkg::ANG_SORT_RIGHT
                                             : tssp_pkg::ANG_SORT_LEFT;
                                angle_next[tssp_pkg::SERVO_LIFT] = tssp_pkg::ANG_LIFT_UP;
                                step_next    = STEP_WAIT_LIFT;
                                step_el_next = '0;
                            end
                        end
                        STEP_WAIT_LIFT:
                        begin
                            if (delay_hit)
                            begin
                                angle_next[tssp_pkg::SERVO_LJAW] = tssp_pkg::ANG_LJAW_OPEN;
                                angle_next[tssp_pkg::SERVO_RJAW] = tssp_pkg::ANG_RJAW_OPEN;
                                step_next    = STEP_FINISH;
                                step_el_next = '0;
                            end
                        end
                        default:
                        begin
                            active_next = 1'b0;
                            step_next   = STEP_CLOSE;
                            if (!held_reg)
                            begin
                                act_el_next = '0;
                            end
                        end
                    endcase
                end
            end
            tssp_pkg::KIND_PICKUP:
            begin
                if (!active_reg)
                begin
                    held_next    = concurrent;
                    active_next  = 1'b1;
                    side_next    = side;
                    step_next    = STEP_CLOSE;
                    step_el_next = '0;
                    taken_next   = 1'b1;
                end
            end
            tssp_pkg::KIND_MOVE:
            begin
                case (move_code)
                    tssp_pkg::MOVE_OPEN:
                    begin
                        angle_next[tssp_pkg::SERVO_LJAW] = tssp_pkg::ANG_LJAW_OPEN;
                        angle_next[tssp_pkg::SERVO_RJAW] = tssp_pkg::ANG_RJAW_OPEN;
                    end
                    tssp_pkg::MOVE_CLOSE:
                    begin
                        angle_next[tssp_pkg::SERVO_LJAW] = tssp_pkg::ANG_LJAW_CLOSED;
                        angle_next[tssp_pkg::SERVO_RJAW] = tssp_pkg::ANG_RJAW_CLOSED;
                    end
                    tssp_pkg::MOVE_LIFT:
                        angle_next[tssp_pkg::SERVO_LIFT] = tssp_pkg::ANG_LIFT_UP;
                    tssp_pkg::MOVE_LOWER:
                        angle_next[tssp_pkg::SERVO_LIFT] = tssp_pkg::ANG_LIFT_DOWN;
                    tssp_pkg::MOVE_SORT_LEFT:
                        angle_next[tssp_pkg::SERVO_SORTER] = tssp_pkg::ANG_SORT_LEFT;
                    tssp_pkg::MOVE_SORT_RIGHT:
                        angle_next[tssp_pkg::SERVO_SORTER] = tssp_pkg::ANG_SORT_RIGHT;
                    tssp_pkg::MOVE_SORT_CENTER:
                        angle_next[tssp_pkg::SERVO_SORTER] = tssp_pkg::ANG_SORT_CENTER;
                    tssp_pkg::MOVE_DEP_LEFT:
                        angle_next[tssp_pkg::SERVO_DEPOSIT] = tssp_pkg::ANG_DEP_LEFT;
                    tssp_pkg::MOVE_DEP_CENTER:
                        angle_next[tssp_pkg::SERVO_DEPOSIT] = tssp_pkg::ANG_DEP_CENTER;
                    tssp_pkg::MOVE_DEP_RIGHT:
                        angle_next[tssp_pkg::SERVO_DEPOSIT] = tssp_pkg::ANG_DEP_RIGHT;
                    tssp_pkg::MOVE_RESET_POSE:
                    begin
                        angle_next[tssp_pkg::SERVO_LIFT]   = tssp_pkg::ANG_LIFT_DOWN;
                        angle_next[tssp_pkg::SERVO_SORTER] = tssp_pkg::ANG_SORT_CENTER;
                        angle_next[tssp_pkg::SERVO_LJAW]   = tssp_pkg::ANG_LJAW_OPEN;
                        angle_next[tssp_pkg::SERVO_RJAW]   = tssp_pkg::ANG_RJAW_OPEN;
                    end
                    default:
                        known = 1'b0;
                endcase
                if (known && !concurrent)
                begin
                    act_el_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            side_reg    <= 1'b0;
            step_reg    <= STEP_CLOSE;
            step_el_reg <= '0;
            act_el_reg  <= '0;
            held_reg    <= 1'b0;
            taken_reg   <= 1'b0;
            angle_reg[tssp_pkg::SERVO_LIFT]    <= tssp_pkg::ANG_LIFT_DOWN;
            angle_reg[tssp_pkg::SERVO_LJAW]    <= tssp_pkg::ANG_LJAW_OPEN;
            angle_reg[tssp_pkg::SERVO_RJAW]    <= tssp_pkg::ANG_RJAW_OPEN;
            angle_reg[tssp_pkg::SERVO_SORTER]  <= tssp_pkg::ANG_SORT_CENTER;
            angle_reg[tssp_pkg::SERVO_DEPOSIT] <= tssp_pkg::ANG_DEP_REST;
        end
        else if (apply)
        begin
            active_reg  <= active_next;
            side_reg    <= side_next;
            step_reg    <= step_next;
            step_el_reg <= step_el_next;
            act_el_reg  <= act_el_next;
            held_reg    <= held_next;
            taken_reg   <= taken_next;
            angle_reg   <= angle_next;
        end
    end

    assign angles       = angle_reg;
    assign status.busy  = active_reg;
    assign status.avail = CW'(act_el_reg) > CW'(cooldown);
    assign status.taken = taken_reg;

endmodule

### rtl/tssp_pulse.sv
// Shared angle-to-pulse unit: one multiply, then a two-bits-per-cycle
// restoring divide by the angular range, floor correction and saturation.
// Depends on tssp_pkg.
module tssp_pulse (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  tssp_pkg::angle_t                 angle,
    input  tssp_pkg::pulse_t                 pulse_min,
    input  tssp_pkg::pulse_t                 pulse_max,
    input  logic [tssp_pkg::RANGE_W-1:0]     range,
    output logic                             done,
    output tssp_pkg::pulse_t                 pulse
);

    localparam int PROD_W    = tssp_pkg::PULSE_W + tssp_pkg::ANGLE_W;
    localparam int REM_W     = tssp_pkg::RANGE_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int DIV_STEPS = PROD_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_MUL  = 4'b0010,
        U_DIV  = 4'b0100,
        U_FIX  = 4'b1000
    } ustate_t;

    ustate_t                          state_reg, state_next;
    tssp_pkg::angle_t                 angle_reg;
    tssp_pkg::pulse_t                 span_reg;
    logic                             neg_reg;
    logic [PROD_W-1:0]                dvd_reg, dvd_next;
    logic [REM_W-1:0]                 rem_reg, rem_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    tssp_pkg::pulse_t                 pulse_reg;
    logic                             done_reg;

    logic [REM_W:0]                   t1, t2, dsr;
    logic                             ge1, ge2;
    logic [REM_W-1:0]                 r1;
    logic [PROD_W-1:0]                d1;
    logic [SUM_W-1:0]                 mag, fq, sum;
    tssp_pkg::pulse_t                 fix_val;

    // Two restoring division steps per cycle; quotient bits shift into the dividend.
    always_comb
    begin
        dsr = {1'b0, range};
        t1  = {rem_reg, dvd_reg[PROD_W-1]};
        ge1 = t1 >= dsr;
        r1  = ge1 ? REM_W'(t1 - dsr) : t1[REM_W-1:0];
        d1  = {dvd_reg[PROD_W-2:0], ge1};
        t2  = {r1, d1[PROD_W-1]};
        ge2 = t2 >= dsr;
        rem_next = ge2 ? REM_W'(t2 - dsr) : t2[REM_W-1:0];
        dvd_next = {d1[PROD_W-2:0], ge2};
    end

    // A negative span rounds toward minus infinity when the division is inexact.
    always_comb
    begin
        mag = SUM_W'(dvd_reg) + SUM_W'(neg_reg && (rem_reg != '0));
        fq  = neg_reg ? (~mag + 1'b1) : mag;
        sum = fq + SUM_W'(pulse_min);
        if (range == '0)
        begin
            fix_val = pulse_min;
        end
        else if (sum[SUM_W-1])
        begin
            fix_val = '0;
        end
        else if (sum[SUM_W-2:tssp_pkg::PULSE_W] != '0)
        begin
            fix_val = '1;
        end
        else
        begin
            fix_val = sum[tssp_pkg::PULSE_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    state_next = U_MUL;
                end
            end
            U_MUL:
            begin
                state_next = U_DIV;
                cnt_next   = '0;
            end
            U_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = U_FIX;
                end
            end
            U_FIX:
                state_next = U_IDLE;
            default:
                state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= (state_reg == U_FIX);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            U_IDLE:
            begin
                angle_reg <= angle;
                neg_reg   <= pulse_max < pulse_min;
                span_reg  <= (pulse_max < pulse_min) ? pulse_min - pulse_max
                                                     : pulse_max - pulse_min;
            end
            U_MUL:
            begin
                dvd_reg <= PROD_W'(span_reg) * PROD_W'(angle_reg);
                rem_reg <= '0;
            end
            U_DIV:
            begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
            end
            U_FIX:
                pulse_reg <= fix_val;
            default:
            begin
            end
        endcase
    end

    assign done  = done_reg;
    assign pulse = pulse_reg;

endmodule

### rtl/timed_servo_pickup_sequencer.sv
// Timed servo pickup sequencer, top level; uses tssp_pkg, tssp_ctrl and tssp_pulse.
// Each accepted item (a millisecond tick, a pickup request or a move preset) updates
// the sequence and the five servo angles in the registers of tssp_ctrl; then one shared multiply and
// divide unit converts the angles to pulse widths one servo after another, each with
// ten two-bit division steps. The block accepts no new item until the five results
// are loaded into the output register, which waits for the previous result to be
// taken. A finished result waits in the output register while the next item is
// already being worked on. Configuration writes take effect at once and should be
// made only while the block is idle.
module timed_servo_pickup_sequencer #(
    parameter int TIMER_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tssp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tssp_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           kind,
    input  logic                                 side,
    input  logic [3:0]                           move_code,
    input  logic                                 concurrent,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [11:0]                          lift_pulse_us,
    output logic [11:0]                          left_jaw_pulse_us,
    output logic [11:0]                          right_jaw_pulse_us,
    output logic [11:0]                          sorter_pulse_us,
    output logic [11:0]                          deposit_pulse_us,
    output logic                                 busy_res,
    output logic                                 ready_for_action,
    output logic                                 request_taken
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_LAUNCH  = 4'b0010,
        S_WAIT    = 4'b0100,
        S_DELIVER = 4'b1000
    } state_t;

    state_t                              state_reg, state_next;
    logic [tssp_pkg::CH_W-1:0]           ch_reg, ch_next;
    tssp_pkg::pulse_t                    work_reg [tssp_pkg::NUM_SERVOS];
    logic                                out_valid_reg, out_valid_next;
    tssp_pkg::pulse_t                    out_pulse_reg [tssp_pkg::NUM_SERVOS];
    tssp_pkg::status_t                   out_status_reg;

    tssp_pkg::pulse_t                    pmin_reg, pmax_reg;
    logic [tssp_pkg::RANGE_W-1:0]        range_reg;
    logic [tssp_pkg::MS_W-1:0]           delay_reg, cool_reg;

    logic                                accept;
    logic                                load_out;
    logic                                p_start, p_done;
    tssp_pkg::pulse_t                    p_pulse;
    tssp_pkg::angle_t                    angles [tssp_pkg::NUM_SERVOS];
    tssp_pkg::status_t                   status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmin_reg  <= tssp_pkg::PULSE_MIN_RST;
            pmax_reg  <= tssp_pkg::PULSE_MAX_RST;
            range_reg <= tssp_pkg::RANGE_RST;
            delay_reg <= tssp_pkg::STEP_DLY_RST;
            cool_reg  <= tssp_pkg::COOLDOWN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tssp_pkg::CFG_PULSE_MIN: pmin_reg  <= cfg_data[tssp_pkg::PULSE_W-1:0];
                tssp_pkg::CFG_PULSE_MAX: pmax_reg  <= cfg_data[tssp_pkg::PULSE_W-1:0];
                tssp_pkg::CFG_RANGE:     range_reg <= cfg_data[tssp_pkg::RANGE_W-1:0];
                tssp_pkg::CFG_STEP_DLY:  delay_reg <= cfg_data[tssp_pkg::MS_W-1:0];
                tssp_pkg::CFG_COOLDOWN:  cool_reg  <= cfg_data[tssp_pkg::MS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign p_start  = (state_reg == S_LAUNCH);
    assign load_out = (state_reg == S_DELIVER) && (!out_valid_reg || out_ready);

    tssp_ctrl #(
        .TIMER_BITS (TIMER_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .apply      (accept),
        .kind       (kind),
        .side       (side),
        .move_code  (move_code),
        .concurrent (concurrent),
        .dwell_ms   (delay_reg),
        .cooldown   (cool_reg),
        .angles     (angles),
        .status     (status)
    );

    tssp_pulse u_pulse (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (p_start),
        .angle     (angles[ch_reg]),
        .pulse_min (pmin_reg),
        .pulse_max (pmax_reg),
        .range     (range_reg),
        .done      (p_done),
        .pulse     (p_pulse)
    );

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LAUNCH;
                    ch_next    = '0;
                end
            end
            S_LAUNCH:
                state_next = S_WAIT;
            S_WAIT:
            begin
                if (p_done)
                begin
                    if (ch_reg == tssp_pkg::SERVO_DEPOSIT)
                    begin
                        state_next = S_DELIVER;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_LAUNCH;
                    end
                end
            end
            S_DELIVER:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_WAIT) && p_done)
        begin
            work_reg[ch_reg] <= p_pulse;
        end
        if (load_out)
        begin
            out_pulse_reg  <= work_reg;
            out_status_reg <= status;
        end
    end

    assign out_valid          = out_valid_reg;
    assign lift_pulse_us      = out_pulse_reg[tssp_pkg::SERVO_LIFT];
    assign left_jaw_pulse_us  = out_pulse_reg[tssp_pkg::SERVO_LJAW];
    assign right_jaw_pulse_us = out_pulse_reg[tssp_pkg::SERVO_RJAW];
    assign sorter_pulse_us    = out_pulse_reg[tssp_pkg::SERVO_SORTER];
    assign deposit_pulse_us   = out_pulse_reg[tssp_pkg::SERVO_DEPOSIT];
    assign busy_res           = out_status_reg.busy;
    assign ready_for_action   = out_status_reg.avail;
    assign request_taken      = out_status_reg.taken;

`ifndef SYNTHESIS
    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        p_done |-> (state_reg == S_WAIT))
        else $error("pulse unit finished while no servo was pending");

    a_accept_launches: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_LAUNCH) && (ch_reg == '0))
        else $error("accepted item did not start the first servo");

    a_channel_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ch_reg <= tssp_pkg::SERVO_DEPOSIT)
        else $error("servo index out of range");

    a_deliver_loads: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid && (state_reg == S_IDLE))
        else $error("result was not presented after delivery");
`endif

endmodule
